>>> rtl/egpd_pkg.sv
`timescale 1ns / 1ps

package egpd_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int AC_W      = 16;
	localparam int POWER_W   = 32;
	localparam int FRAC_EXT  = 16;
	localparam int AVG_W     = POWER_W + FRAC_EXT;
	localparam int DIFF_W    = AVG_W + 1;
	localparam int IIR_GAIN  = 655;
	localparam int GAIN_W    = 11;
	localparam int PROD_W    = DIFF_W + GAIN_W;
	localparam int POS_W     = 64;
	localparam int RISE_W    = 4;
	localparam int FALL_W    = 8;
	localparam int PLAT_W    = 10;
	localparam int GAP_W     = 16;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;

	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [AC_W-1:0]    DETECT_RST  = AC_W'(14746);
	localparam logic [AC_W-1:0]    UPPER_RST   = AC_W'(19661);
	localparam logic [AC_W-1:0]    VALLEY_RST  = AC_W'(8192);
	localparam logic [POWER_W-1:0] PWR_THR_RST = POWER_W'(2147);
	localparam logic [RISE_W-1:0]  RISE_RST    = RISE_W'(3);
	localparam logic [FALL_W-1:0]  FALL_RST    = FALL_W'(10);
	localparam logic [PLAT_W-1:0]  PLAT_RST    = PLAT_W'(100);
	localparam logic [GAP_W-1:0]   GAP_RST     = GAP_W'(240);

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_DETECT_THRESHOLD = 3'd0,
		REG_UPPER_LEVEL      = 3'd1,
		REG_VALLEY_LEVEL     = 3'd2,
		REG_POWER_THRESHOLD  = 3'd3,
		REG_RISE_COUNT       = 3'd4,
		REG_FALL_COUNT       = 3'd5,
		REG_PLATEAU_LENGTH   = 3'd6,
		REG_MIN_PEAK_GAP     = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [AC_W-1:0]    detect_threshold;
		logic [AC_W-1:0]    upper_level;
		logic [AC_W-1:0]    valley_level;
		logic [POWER_W-1:0] power_threshold;
		logic [RISE_W-1:0]  rise_count;
		logic [FALL_W-1:0]  fall_count;
		logic [PLAT_W-1:0]  plateau_length;
		logic [GAP_W-1:0]   min_peak_gap;
	} cfg_t;

	typedef struct packed {
		logic [POWER_W-1:0] power;
		logic               inband;
		logic               below_valley;
	} class_t;

endpackage

>>> rtl/egpd_in_if.sv
`timescale 1ns / 1ps

interface egpd_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [egpd_pkg::SAMPLE_W-1:0] sample_i;
	logic signed [egpd_pkg::SAMPLE_W-1:0] sample_q;
	logic        [egpd_pkg::AC_W-1:0]     autocorr;

	modport source (output valid, output sample_i, output sample_q, output autocorr,
		input ready);
	modport sink (input valid, input sample_i, input sample_q, input autocorr,
		output ready);
endinterface

>>> rtl/egpd_out_if.sv
`timescale 1ns / 1ps

interface egpd_out_if;
	logic                             valid;
	logic                             ready;
	logic                             peak_flag;
	logic [egpd_pkg::POWER_W-1:0]     filtered_power;

	modport source (output valid, output peak_flag, output filtered_power, input ready);
	modport sink (input valid, input peak_flag, input filtered_power, output ready);
endinterface

>>> rtl/energy_gated_plateau_detector_top.sv
`timescale 1ns / 1ps

// channel | dir | handshake         | word
// din     | in  | din.valid/ready   | sample_i, sample_q, autocorr
// dout    | out | dout.valid/ready  | peak_flag, filtered_power
// cfg     | in  | cfg_we            | cfg_index, cfg_data
//
// The back end registers the gain multiply as it pops a word; accumulate, compare and mode
// update follow in its update phase, and it pops no new word until that update is done.
// A word passes the front register, the queue, the back end multiply and output registers.
// arst_n clears the queue, the mode machine, counters and the power average.
// The front end keeps taking words while the queue has room; dout stalls hold the back end.
module energy_gated_plateau_detector_top #(
	parameter int QUEUE_DEPTH = egpd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [egpd_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [egpd_pkg::CFG_DATA_W-1:0]     cfg_data,
	egpd_in_if.sink                             din,
	egpd_out_if.source                          dout
);
	import egpd_pkg::*;

	cfg_t   cfg_q;
	logic   push;
	logic   full;
	logic   pop;
	logic   empty;
	class_t push_word;
	class_t pop_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.detect_threshold <= DETECT_RST;
			cfg_q.upper_level      <= UPPER_RST;
			cfg_q.valley_level     <= VALLEY_RST;
			cfg_q.power_threshold  <= PWR_THR_RST;
			cfg_q.rise_count       <= RISE_RST;
			cfg_q.fall_count       <= FALL_RST;
			cfg_q.plateau_length   <= PLAT_RST;
			cfg_q.min_peak_gap     <= GAP_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_DETECT_THRESHOLD: cfg_q.detect_threshold <= cfg_data[AC_W-1:0];
				REG_UPPER_LEVEL:      cfg_q.upper_level      <= cfg_data[AC_W-1:0];
				REG_VALLEY_LEVEL:     cfg_q.valley_level     <= cfg_data[AC_W-1:0];
				REG_POWER_THRESHOLD:  cfg_q.power_threshold  <= cfg_data[POWER_W-1:0];
				REG_RISE_COUNT:       cfg_q.rise_count       <= cfg_data[RISE_W-1:0];
				REG_FALL_COUNT:       cfg_q.fall_count       <= cfg_data[FALL_W-1:0];
				REG_PLATEAU_LENGTH:   cfg_q.plateau_length   <= cfg_data[PLAT_W-1:0];
				REG_MIN_PEAK_GAP:     cfg_q.min_peak_gap     <= cfg_data[GAP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	egpd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.din       (din),
		.push      (push),
		.push_word (push_word),
		.full      (full)
	);

	egpd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.full      (full),
		.pop       (pop),
		.pop_word  (pop_word),
		.empty     (empty)
	);

	egpd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.pop_word (pop_word),
		.empty    (empty),
		.pop      (pop),
		.dout     (dout)
	);

endmodule

>>> rtl/egpd_front.sv
`timescale 1ns / 1ps

module egpd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  egpd_pkg::cfg_t    cfg,
	egpd_in_if.sink           din,
	output logic              push,
	output egpd_pkg::class_t  push_word,
	input  logic              full
);
	import egpd_pkg::*;

	logic                      v_s1;
	class_t                    word_s1;
	logic signed [2*SAMPLE_W-1:0] ii_c;
	logic signed [2*SAMPLE_W-1:0] qq_c;
	class_t                    word_c;

	assign ii_c = din.sample_i * din.sample_i;
	assign qq_c = din.sample_q * din.sample_q;

	always_comb begin
		word_c.power        = POWER_W'(unsigned'(ii_c)) + POWER_W'(unsigned'(qq_c));
		word_c.inband       = (din.autocorr > cfg.detect_threshold) &&
			(din.autocorr < cfg.upper_level);
		word_c.below_valley = din.autocorr < cfg.valley_level;
	end

	assign push      = v_s1 && !full;
	assign push_word = word_s1;
	assign din.ready = !v_s1 || !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (din.ready) begin
			v_s1 <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (din.valid && din.ready) begin
			word_s1 <= word_c;
		end
	end

	a_hold_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && full) |=> (v_s1 && $stable(word_s1)))
		else $error("front word dropped while queue full");

	a_no_push_empty: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> v_s1)
		else $error("push without a held word");

	a_power_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (word_s1.power <= (POWER_W'(1) << (2*SAMPLE_W-1))))
		else $error("sample power out of range");

endmodule

>>> rtl/egpd_fifo.sv
`timescale 1ns / 1ps

module egpd_fifo #(
	parameter int DEPTH = egpd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  egpd_pkg::class_t  push_word,
	output logic              full,
	input  logic              pop,
	output egpd_pkg::class_t  pop_word,
	output logic              empty
);
	import egpd_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	class_t             mem [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;

	assign full     = cnt_q == CNT_W'(DEPTH);
	assign empty    = cnt_q == '0;
	assign pop_word = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("queue count overflow");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("push into full queue");

	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("pop from empty queue");

endmodule

>>> rtl/egpd_back.sv
`timescale 1ns / 1ps

module egpd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  egpd_pkg::cfg_t    cfg,
	input  egpd_pkg::class_t  pop_word,
	input  logic              empty,
	output logic              pop,
	egpd_out_if.source        dout
);
	import egpd_pkg::*;

	typedef enum logic {
		PH_IDLE,
		PH_UPD
	} phase_t;

	typedef enum logic [1:0] {
		MODE_NO_SIGNAL,
		MODE_ENERGY_VALID,
		MODE_VALLEY,
		MODE_PLATEAU
	} mode_t;

	phase_t                    ph_q;
	mode_t                     mode_q;
	logic [AVG_W-1:0]          avg_q;
	logic [FALL_W-1:0]         fall_q;
	logic [RISE_W-1:0]         rise_q;
	logic [PLAT_W-1:0]         plat_q;
	logic [POS_W-1:0]          gap_q;
	logic                      out_v_q;
	logic                      peak_q;
	logic [POWER_W-1:0]        pwr_q;

	logic signed [PROD_W-1:0]  prod_s1;
	logic                      inband_s1;
	logic                      below_s1;
	logic                      gap_gt_s1;

	logic signed [DIFF_W-1:0]  diff_c;
	logic signed [PROD_W-1:0]  prod_c;
	logic signed [DIFF_W-1:0]  sum_c;
	logic [AVG_W-1:0]          avg_n;
	logic [POWER_W-1:0]        pwr_n;
	logic                      high_c;
	logic                      upd;
	mode_t                     mode_n;
	logic [FALL_W-1:0]         fall_n;
	logic [RISE_W-1:0]         rise_n;
	logic [PLAT_W-1:0]         plat_n;
	logic                      peak_n;
	logic                      peak_evt;

	assign pop = (ph_q == PH_IDLE) && !empty;
	assign upd = (ph_q == PH_UPD) && (!out_v_q || dout.ready);

	assign diff_c = $signed({1'b0, pop_word.power, {FRAC_EXT{1'b0}}}) - $signed({1'b0, avg_q});
	assign prod_c = diff_c * $signed(GAIN_W'(IIR_GAIN));

	assign sum_c  = $signed({1'b0, avg_q}) + DIFF_W'(prod_s1 >>> FRAC_EXT);
	assign avg_n  = sum_c[AVG_W-1:0];
	assign pwr_n  = avg_n[AVG_W-1:FRAC_EXT];
	assign high_c = pwr_n > cfg.power_threshold;

	always_comb begin
		logic [FALL_W-1:0] fall_inc;
		logic [RISE_W-1:0] rise_inc;
		logic [PLAT_W-1:0] plat_inc;
		mode_n   = mode_q;
		fall_n   = fall_q;
		rise_n   = rise_q;
		plat_n   = plat_q;
		peak_n   = 1'b0;
		peak_evt = 1'b0;
		fall_inc = (fall_q == '1) ? fall_q : fall_q + 1'b1;
		rise_inc = (rise_q == '1) ? rise_q : rise_q + 1'b1;
		plat_inc = (plat_q == '1) ? plat_q : plat_q + 1'b1;

		if (!high_c) begin
			fall_n = fall_inc;
			if (fall_inc >= cfg.fall_count) begin
				mode_n = MODE_NO_SIGNAL;
				fall_n = '0;
			end
		end else begin
			fall_n = '0;
		end

		case (mode_n)
			MODE_NO_SIGNAL: begin
				if (high_c) begin
					rise_n = rise_inc;
					if (rise_inc >= cfg.rise_count) begin
						mode_n = MODE_ENERGY_VALID;
						rise_n = '0;
					end
				end else begin
					rise_n = '0;
				end
			end
			MODE_ENERGY_VALID: begin
				if (below_s1) begin
					mode_n = MODE_VALLEY;
				end
			end
			MODE_VALLEY: begin
				if (inband_s1) begin
					mode_n = MODE_PLATEAU;
					plat_n = '0;
				end
			end
			default: begin
				if (inband_s1) begin
					plat_n = plat_inc;
					if (plat_inc >= cfg.plateau_length) begin
						plat_n   = '0;
						peak_n   = gap_gt_s1;
						peak_evt = 1'b1;
						mode_n   = MODE_ENERGY_VALID;
					end
				end else begin
					plat_n = '0;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			prod_s1   <= prod_c;
			inband_s1 <= pop_word.inband;
			below_s1  <= pop_word.below_valley;
			gap_gt_s1 <= (|gap_q[POS_W-1:GAP_W]) || (gap_q[GAP_W-1:0] > cfg.min_peak_gap);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= PH_IDLE;
			mode_q  <= MODE_NO_SIGNAL;
			avg_q   <= '0;
			fall_q  <= '0;
			rise_q  <= '0;
			plat_q  <= '0;
			gap_q   <= '0;
			out_v_q <= 1'b0;
			peak_q  <= 1'b0;
			pwr_q   <= '0;
		end else begin
			if (upd) begin
				out_v_q <= 1'b1;
			end else if (dout.ready) begin
				out_v_q <= 1'b0;
			end
			case (ph_q)
				PH_IDLE: begin
					if (pop) begin
						ph_q <= PH_UPD;
					end
				end
				PH_UPD: begin
					if (upd) begin
						ph_q    <= PH_IDLE;
						mode_q  <= mode_n;
						avg_q   <= avg_n;
						fall_q  <= fall_n;
						rise_q  <= rise_n;
						plat_q  <= plat_n;
						gap_q   <= peak_evt ? POS_W'(1) : gap_q + 1'b1;
						peak_q  <= peak_n;
						pwr_q   <= pwr_n;
					end
				end
				default: begin
					ph_q <= PH_IDLE;
				end
			endcase
		end
	end

	assign dout.valid          = out_v_q;
	assign dout.peak_flag      = peak_q;
	assign dout.filtered_power = pwr_q;

	a_rise_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q != MODE_NO_SIGNAL) |-> (rise_q == '0))
		else $error("rise counter live outside no-signal mode");

	a_out_from_upd: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> $past(ph_q == PH_UPD))
		else $error("word issued without an update");

	a_gap_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(upd && peak_evt) |=> (gap_q == POS_W'(1) && mode_q == MODE_ENERGY_VALID))
		else $error("peak spacing not restarted");

	a_peak_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(upd && peak_n) |-> gap_gt_s1)
		else $error("peak reported inside minimum gap");

endmodule

>>> tb/sv/egpd_detect_check.sv
`timescale 1ns / 1ps

module egpd_detect_check (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [egpd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [egpd_pkg::CFG_DATA_W-1:0]  cfg_data,
	egpd_in_if                               din,
	egpd_out_if                              dout,
	output int                               mismatches,
	output int                               words_pending
);
	import egpd_pkg::*;

	typedef enum logic [1:0] {
		DET_NO_SIGNAL,
		DET_ENERGY_VALID,
		DET_VALLEY,
		DET_PLATEAU
	} det_mode_t;

	typedef struct {
		logic               peak_flag;
		logic [POWER_W-1:0] filtered_power;
	} det_word_t;

	cfg_t              regs;
	logic [AVG_W-1:0]  power_avg;
	det_mode_t         mode;
	logic [FALL_W-1:0] fall_run;
	logic [RISE_W-1:0] rise_run;
	logic [PLAT_W-1:0] plateau_run;
	logic [POS_W-1:0]  position;
	logic [POS_W-1:0]  last_peak_at;
	det_word_t         expected_words[$];
	det_word_t         head;

	task automatic report_mismatch(input string field, input logic [31:0] got,
		input logic [31:0] want);
		$display("%0t ns: mismatch on %s: got %h, expected %h", $time, field, got, want);
		mismatches++;
	endtask

	task automatic predict_detection(input logic signed [SAMPLE_W-1:0] si,
		input logic signed [SAMPLE_W-1:0] sq, input logic [AC_W-1:0] ac);
		longint             sample_power;
		longint             diff;
		longint             step;
		logic [POWER_W-1:0] pwr;
		logic               hot;
		logic               in_band;
		logic               peak;
		sample_power = longint'(si) * longint'(si) + longint'(sq) * longint'(sq);
		// one-pole smoothing, floor on the scaled difference
		diff = (sample_power <<< FRAC_EXT) - longint'(power_avg);
		step = (diff * IIR_GAIN) >>> 16;
		power_avg = AVG_W'(longint'(power_avg) + step);
		pwr = power_avg[AVG_W-1:FRAC_EXT];
		hot = pwr > regs.power_threshold;
		peak = 1'b0;

		if (!hot) begin
			if (fall_run != '1)
				fall_run++;
			if (fall_run >= regs.fall_count) begin
				mode = DET_NO_SIGNAL;
				fall_run = '0;
			end
		end else begin
			fall_run = '0;
		end

		in_band = ac > regs.detect_threshold && ac < regs.upper_level;

		case (mode)
			DET_NO_SIGNAL: begin
				if (hot) begin
					if (rise_run != '1)
						rise_run++;
					if (rise_run >= regs.rise_count) begin
						mode = DET_ENERGY_VALID;
						rise_run = '0;
					end
				end else begin
					rise_run = '0;
				end
			end
			DET_ENERGY_VALID: begin
				if (ac < regs.valley_level)
					mode = DET_VALLEY;
			end
			DET_VALLEY: begin
				if (in_band) begin
					mode = DET_PLATEAU;
					plateau_run = '0;
				end
			end
			default: begin
				if (in_band) begin
					if (plateau_run != '1)
						plateau_run++;
					if (plateau_run >= regs.plateau_length) begin
						plateau_run = '0;
						if (position - last_peak_at > POS_W'(regs.min_peak_gap))
							peak = 1'b1;
						last_peak_at = position;
						mode = DET_ENERGY_VALID;
					end
				end else begin
					plateau_run = '0;
				end
			end
		endcase

		position++;
		expected_words.push_back('{peak_flag: peak, filtered_power: pwr});
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs = '{detect_threshold: DETECT_RST, upper_level: UPPER_RST,
				valley_level: VALLEY_RST, power_threshold: PWR_THR_RST,
				rise_count: RISE_RST, fall_count: FALL_RST,
				plateau_length: PLAT_RST, min_peak_gap: GAP_RST};
			power_avg = '0;
			mode = DET_NO_SIGNAL;
			fall_run = '0;
			rise_run = '0;
			plateau_run = '0;
			position = '0;
			last_peak_at = '0;
			mismatches = 0;
			expected_words.delete();
		end else begin
			if (dout.valid && dout.ready) begin
				if (expected_words.size() == 0) begin
					report_mismatch("word with nothing expected, filtered_power",
						dout.filtered_power, '0);
				end else begin
					head = expected_words.pop_front();
					if (dout.peak_flag !== head.peak_flag)
						report_mismatch("peak_flag", 32'(dout.peak_flag),
							32'(head.peak_flag));
					if (dout.filtered_power !== head.filtered_power)
						report_mismatch("filtered_power", dout.filtered_power,
							head.filtered_power);
				end
			end
			if (din.valid && din.ready)
				predict_detection(din.sample_i, din.sample_q, din.autocorr);
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_DETECT_THRESHOLD: regs.detect_threshold = cfg_data[AC_W-1:0];
					REG_UPPER_LEVEL:      regs.upper_level = cfg_data[AC_W-1:0];
					REG_VALLEY_LEVEL:     regs.valley_level = cfg_data[AC_W-1:0];
					REG_POWER_THRESHOLD:  regs.power_threshold = cfg_data[POWER_W-1:0];
					REG_RISE_COUNT:       regs.rise_count = cfg_data[RISE_W-1:0];
					REG_FALL_COUNT:       regs.fall_count = cfg_data[FALL_W-1:0];
					REG_PLATEAU_LENGTH:   regs.plateau_length = cfg_data[PLAT_W-1:0];
					REG_MIN_PEAK_GAP:     regs.min_peak_gap = cfg_data[GAP_W-1:0];
					default: begin
					end
				endcase
			end
		end
		words_pending = expected_words.size();
	end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import egpd_pkg::*;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	int                     mismatches;
	int                     words_pending;
	int                     send_idle = 6;
	int                     recv_stall = 53;
	int                     sent = 0;
	cfg_t                   shape;

	egpd_in_if  din();
	egpd_out_if dout();

	energy_gated_plateau_detector_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.din       (din),
		.dout      (dout)
	);

	egpd_detect_check u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.din           (din),
		.dout          (dout),
		.mismatches    (mismatches),
		.words_pending (words_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		dout.ready <= ($urandom_range(99) >= recv_stall);
	end

	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic logic signed [SAMPLE_W-1:0] strong_level();
		logic signed [SAMPLE_W-1:0] mag;
		mag = SAMPLE_W'($urandom_range(16384, 32767));
		return $urandom_range(1) ? -mag : mag;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] weak_level();
		return SAMPLE_W'($urandom_range(0, 511) - 256);
	endfunction

	function automatic cfg_t pick_config(input int n);
		cfg_t c;
		if (n == 0)
			return '1;
		if (n == 5)
			return '0;
		c.detect_threshold = AC_W'($urandom_range(2000, 16000));
		c.upper_level = AC_W'(c.detect_threshold + $urandom_range(2, 12000));
		c.valley_level = AC_W'($urandom_range(0, c.detect_threshold));
		c.power_threshold = POWER_W'((1 << $urandom_range(20, 26)) + $urandom_range(0, 65535));
		c.rise_count = RISE_W'($urandom_range(0, 15));
		c.fall_count = FALL_W'($urandom_range(0, 40));
		c.plateau_length = ($urandom_range(3) == 0) ? PLAT_W'($urandom_range(60, 120))
			: PLAT_W'($urandom_range(0, 40));
		c.min_peak_gap = GAP_W'($urandom_range(0, 300));
		return c;
	endfunction

	task automatic send_word(input logic signed [SAMPLE_W-1:0] si,
		input logic signed [SAMPLE_W-1:0] sq, input logic [AC_W-1:0] ac);
		while ($urandom_range(99) < send_idle) begin
			din.valid <= 1'b0;
			@(posedge clk);
		end
		din.valid <= 1'b1;
		din.sample_i <= si;
		din.sample_q <= sq;
		din.autocorr <= ac;
		do
			@(posedge clk);
		while (din.ready !== 1'b1);
		sent++;
	endtask

	// hold the input side until every word sent has come back
	task automatic drain();
		din.valid <= 1'b0;
		do
			@(negedge clk);
		while (words_pending != 0);
		@(posedge clk);
	endtask

	task automatic program_regs(input cfg_t c);
		cfg_reg_t              r;
		logic [CFG_DATA_W-1:0] word;
		r = r.first();
		do begin
			case (r)
				REG_DETECT_THRESHOLD: word = {16'($urandom), c.detect_threshold};
				REG_UPPER_LEVEL:      word = {16'($urandom), c.upper_level};
				REG_VALLEY_LEVEL:     word = {16'($urandom), c.valley_level};
				REG_POWER_THRESHOLD:  word = c.power_threshold;
				REG_RISE_COUNT:       word = {28'($urandom), c.rise_count};
				REG_FALL_COUNT:       word = {24'($urandom), c.fall_count};
				REG_PLATEAU_LENGTH:   word = {22'($urandom), c.plateau_length};
				default:              word = {16'($urandom), c.min_peak_gap};
			endcase
			cfg_we <= 1'b1;
			cfg_index <= r;
			cfg_data <= word;
			@(posedge clk);
			r = r.next();
		end while (r != r.first());
		cfg_we <= 1'b0;
		shape = c;
	endtask

	// signal lead-in, valley, in-band plateau, then a noise tail; one burst in five is random words only
	task automatic run_burst();
		int          lead_len;
		int          valley_len;
		int          plat_len;
		int          tail_len;
		logic [15:0] ac;
		if ($urandom_range(4) == 0) begin
			repeat ($urandom_range(5, 30))
				send_word(16'($urandom), 16'($urandom), 16'($urandom));
			return;
		end
		lead_len = $urandom_range(2, 30);
		valley_len = $urandom_range(1, 3);
		plat_len = (shape.plateau_length > 120) ? 120 : shape.plateau_length;
		plat_len += $urandom_range(0, 3);
		tail_len = ($urandom_range(7) == 0) ? $urandom_range(150, 300) : $urandom_range(0, 30);
		repeat (lead_len)
			send_word(strong_level(), strong_level(),
				16'($urandom_range(shape.valley_level, 16'hFFFF)));
		repeat (valley_len) begin
			ac = (shape.valley_level == 0) ? 16'($urandom)
				: 16'($urandom_range(0, shape.valley_level - 1));
			send_word(strong_level(), strong_level(), ac);
		end
		repeat (plat_len) begin
			if (shape.upper_level > shape.detect_threshold + 1 && $urandom_range(24) != 0)
				ac = 16'($urandom_range(shape.detect_threshold + 1, shape.upper_level - 1));
			else
				ac = 16'($urandom);
			send_word(strong_level(), strong_level(), ac);
		end
		repeat (tail_len)
			send_word(weak_level(), weak_level(), 16'($urandom));
	endtask

	initial begin
		int block_start;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		din.valid <= 1'b0;
		din.sample_i <= '0;
		din.sample_q <= '0;
		din.autocorr <= '0;
		arst_n <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values of the registers
		send_word(16'sd32767, 16'sd32767, 16'hFFFF);
		send_word(-16'sd32768, -16'sd32768, 16'h0000);
		send_word(16'sd0, 16'sd0, 16'd14746);
		send_word(-16'sd1, 16'sd1, 16'd19661);
		drain();

		program_regs('{detect_threshold: 16'd14746, upper_level: 16'd19661,
			valley_level: 16'd8192, power_threshold: 32'd0, rise_count: 4'd1,
			fall_count: 8'd1, plateau_length: 10'd1, min_peak_gap: 16'd0});
		send_word(16'sd0, 16'sd0, 16'd30000);
		send_word(16'sd32767, 16'sd32767, 16'd30000);
		send_word(-16'sd32768, -16'sd32768, 16'd8192);
		send_word(-16'sd32768, 16'sd32767, 16'd8191);
		send_word(16'sd32767, -16'sd32768, 16'd14746);
		send_word(16'sd1000, 16'sd1000, 16'd19661);
		send_word(16'sd1000, 16'sd1000, 16'd14747);
		send_word(16'sd1000, 16'sd1000, 16'd19660);
		send_word(16'sd1000, 16'sd1000, 16'd0);
		send_word(16'sd1000, 16'sd1000, 16'd15000);
		send_word(16'sd1000, 16'sd1000, 16'd15000);
		send_word(16'sd0, 16'sd0, 16'hFFFF);
		send_word(-16'sd1, -16'sd1, 16'd0);

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle = 6;
					recv_stall = 53;
				end
				1: begin
					send_idle = 53;
					recv_stall = 6;
				end
				default: begin
					send_idle = 0;
					recv_stall = 0;
				end
			endcase
			for (int blk = 0; blk < 4; blk++) begin
				drain();
				program_regs(pick_config(ph * 4 + blk));
				block_start = sent;
				while (sent - block_start < 64) begin
					run_burst();
					if ($urandom_range(39) == 0)
						drain();
				end
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> energy_gated_plateau_detector_top.f
rtl/egpd_pkg.sv
rtl/egpd_in_if.sv
rtl/egpd_out_if.sv
rtl/egpd_front.sv
rtl/egpd_fifo.sv
rtl/egpd_back.sv
rtl/energy_gated_plateau_detector_top.sv
tb/sv/egpd_detect_check.sv
tb/sv/tb_top.sv
